[hw/rtl/ils_pkg.sv]
// shared types and constants for the indexed list store
`timescale 1ns / 1ps

package ils_pkg;

   // fixed field widths
   localparam int OP_W     = 3;
   localparam int IDX_W    = 7;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;
   localparam int CAP_W    = 7;

   // stream payload widths, padded to whole bytes
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 48;

   // store defaults
   localparam int         DEPTH_DEFAULT = 64;
   localparam logic [6:0] CAP_RESET     = 7'd64;

   // operation codes
   typedef enum logic [2:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_INSERT     = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_POP_FRONT  = 3'd4,
      OP_REMOVE     = 3'd5,
      OP_GET        = 3'd6,
      OP_CLEAR      = 3'd7
   } op_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_FULL   = 2'd2,
      ST_BADIDX = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SHIFT  = 5'b00010,
      S_DRAIN  = 5'b00100,
      S_FINISH = 5'b01000,
      S_RESP   = 5'b10000
   } state_type;

endpackage

[hw/rtl/indexed_list_store_core.sv]
// ordered list store with insert/remove shifting through a registered-read store
// steps: a rejected op or clear goes from idle straight to the result state, an append
// through finish, and an op that reads n stored entries through shift, drain and finish
// (get and pop back 1, pop front cnt, insert and remove cnt - index, n up to DEPTH)
// throughput: one transaction at a time; the next request is taken once the result loads
// reset: count cleared, capacity set to 64, stored words left undefined
`timescale 1ns / 1ps

module indexed_list_store_core
   import ils_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // operation[2:0], index[9:3], value[41:10]
   // result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // status[1:0], read_value[33:2], count[40:34]
   // capacity register write
   input  logic                   csr_wr_en,
   input  logic [CAP_W-1:0]       csr_wr_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int W  = (CW > IDX_W) ? CW : IDX_W;

   // registers
   state_type         state_ff, state_in;
   logic [CAP_W-1:0]  cap_ff;
   logic [CW-1:0]     count_ff, count_in;
   logic              ins_ff, ins_in;
   logic              get_ff, get_in;
   logic [AW-1:0]     pos_ff, pos_in;
   logic [AW-1:0]     ptr_ff, ptr_in;
   logic [AW-1:0]     end_ff, end_in;
   logic [DATA_W-1:0] value_ff, value_in;
   status_type        status_ff, status_in;
   logic [DATA_W-1:0] readv_ff, readv_in;
   logic              rd_vld_ff;
   logic [AW-1:0]     rd_addr_ff;
   logic [DATA_W-1:0] rd_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   // store
   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [DATA_W-1:0] mem_wdata;
   logic              rd_en;

   // request decode
   op_type         req_op;
   logic [W-1:0]   idx_w;
   logic [W-1:0]   cnt_w;
   logic [W-1:0]   cap_eff;
   logic [W-1:0]   ins_pos;
   logic [W-1:0]   rm_pos;
   logic           req_fire;
   logic           capture;
   logic [AW-1:0]  ptr_step;

   assign req_op   = op_type'(req_tdata[2:0]);
   assign idx_w    = W'(req_tdata[9:3]);
   assign cnt_w    = W'(count_ff);
   assign cap_eff  = (W'(cap_ff) > W'(DEPTH)) ? W'(DEPTH) : W'(cap_ff);
   assign req_fire = req_tvalid && req_tready;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // target position per operation
   always_comb begin
      if (req_op == OP_PUSH_BACK) begin
         ins_pos = cnt_w;
      end else if (req_op == OP_PUSH_FRONT) begin
         ins_pos = '0;
      end else begin
         ins_pos = idx_w;
      end
      if (req_op == OP_POP_BACK) begin
         rm_pos = cnt_w - W'(1);
      end else if (req_op == OP_POP_FRONT) begin
         rm_pos = '0;
      end else begin
         rm_pos = idx_w;
      end
   end

   // shared address stepper: down for insert, up for remove
   assign ptr_step = ins_ff ? (ptr_ff - AW'(1)) : (ptr_ff + AW'(1));

   // first read of a remove or get is the returned word, not a moved one
   assign capture = !ins_ff && (rd_addr_ff == pos_ff);

   // store write port
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = rd_data_ff;
      if (((state_ff == S_SHIFT) || (state_ff == S_DRAIN)) && rd_vld_ff && !capture) begin
         mem_we    = 1'b1;
         mem_waddr = ins_ff ? (rd_addr_ff + AW'(1)) : (rd_addr_ff - AW'(1));
      end else if ((state_ff == S_FINISH) && ins_ff) begin
         mem_we    = 1'b1;
         mem_waddr = pos_ff;
         mem_wdata = value_ff;
      end
   end

   assign rd_en = (state_ff == S_SHIFT);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ins_in       = ins_ff;
      get_in       = get_ff;
      pos_in       = pos_ff;
      ptr_in       = ptr_ff;
      end_in       = end_ff;
      value_in     = value_ff;
      status_in    = status_ff;
      readv_in     = readv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (((state_ff == S_SHIFT) || (state_ff == S_DRAIN)) && rd_vld_ff && capture) begin
         readv_in = rd_data_ff;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               value_in  = req_tdata[41:10];
               readv_in  = '0;
               status_in = ST_OK;
               get_in    = (req_op == OP_GET);
               unique case (req_op) inside
                  OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: begin
                     ins_in = 1'b1;
                     pos_in = AW'(ins_pos);
                     ptr_in = AW'(cnt_w - W'(1));
                     end_in = AW'(ins_pos);
                     if (cnt_w >= cap_eff) begin
                        status_in = ST_FULL;
                        state_in  = S_RESP;
                     end else if (ins_pos > cnt_w) begin
                        status_in = ST_BADIDX;
                        state_in  = S_RESP;
                     end else if (ins_pos == cnt_w) begin
                        state_in = S_FINISH;
                     end else begin
                        state_in = S_SHIFT;
                     end
                  end
                  OP_POP_BACK, OP_POP_FRONT, OP_REMOVE, OP_GET: begin
                     ins_in = 1'b0;
                     pos_in = AW'(rm_pos);
                     ptr_in = AW'(rm_pos);
                     end_in = (req_op == OP_GET) ? AW'(rm_pos) : AW'(cnt_w - W'(1));
                     if (cnt_w == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = S_RESP;
                     end else if (rm_pos >= cnt_w) begin
                        status_in = ST_BADIDX;
                        state_in  = S_RESP;
                     end else begin
                        state_in = S_SHIFT;
                     end
                  end
                  default: begin
                     count_in = '0;
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_SHIFT: begin
            if (ptr_ff == end_ff) begin
               state_in = S_DRAIN;
            end else begin
               ptr_in = ptr_step;
            end
         end
         S_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (ins_ff) begin
               count_in = count_ff + CW'(1);
            end else if (!get_ff) begin
               count_in = count_ff - CW'(1);
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_TDATA_W'({COUNT_W'(count_ff), readv_ff, status_ff});
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_en;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ins_ff      <= ins_in;
      get_ff      <= get_in;
      pos_ff      <= pos_in;
      ptr_ff      <= ptr_in;
      end_ff      <= end_in;
      value_ff    <= value_in;
      status_ff   <= status_in;
      readv_ff    <= readv_in;
      rsp_data_ff <= rsp_data_in;
      rd_addr_ff  <= ptr_ff;
   end

   // store write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[ptr_ff];
      end
   end

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("list count above store depth");

   a_rd_after_shift: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> ($past(state_ff) == S_SHIFT))
      else $error("read data valid without a shift read");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != S_IDLE))
      else $error("sequencer idle right after accepting a transaction");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_IDLE) || (state_ff == S_RESP)) |-> !mem_we)
      else $error("store written outside an operation");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |=> $stable(count_ff))
      else $error("count changed during a shift");

endmodule

[verif/indexed_list_store_core_tb.sv]
// self-checking testbench for the indexed list store core
`timescale 1ns / 1ps

module indexed_list_store_core_tb;
   import ils_pkg::*;

   localparam int DEPTH         = DEPTH_DEFAULT;
   localparam int MAX_CYCLES    = 1000000;
   localparam int SETTLE_CYCLES = DEPTH + 8;
   localparam int REPORT_LIMIT  = 10;
   localparam int PAD_W         = REQ_TDATA_W - OP_W - IDX_W - DATA_W;

   typedef enum int {MIX_EVEN, MIX_FILL, MIX_DRAIN} mix_type;

   typedef struct packed {
      status_type          st;
      logic [DATA_W-1:0]   word;
      logic [COUNT_W-1:0]  cnt;
   } list_result_type;

   typedef struct packed {
      op_type              op;
      logic [IDX_W-1:0]    idx;
      logic [DATA_W-1:0]   val;
      bit                  known;
      list_result_type     res;
   } op_row_type;

   typedef struct packed {
      logic [CAP_W-1:0]    cap;
      mix_type             mix;
      int                  items;
   } phase_row_type;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_wr_en   = 1'b0;
   logic [CAP_W-1:0]       csr_wr_data = '0;

   // shadow copy of the list contents, count and capacity
   logic [DATA_W-1:0]      shadow_words [DEPTH];
   int unsigned            shadow_count = 0;
   logic [CAP_W-1:0]       shadow_cap   = CAP_RESET;

   list_result_type        pending_results [$];
   int unsigned            error_count  = 0;
   int unsigned            cycle_count  = 0;
   int unsigned            ready_hold   = 0;
   bit                     ready_calm   = 1'b0;

   // directed list: empty, extremes, bad index, append, clear
   op_row_type directed_ops [24] = '{
      '{OP_POP_BACK,   7'd0,   32'h0,        1'b1, '{ST_EMPTY,  32'h0,        7'd0}},
      '{OP_POP_FRONT,  7'd0,   32'h0,        1'b1, '{ST_EMPTY,  32'h0,        7'd0}},
      '{OP_REMOVE,     7'd0,   32'h0,        1'b1, '{ST_EMPTY,  32'h0,        7'd0}},
      '{OP_GET,        7'd127, 32'h0,        1'b1, '{ST_EMPTY,  32'h0,        7'd0}},
      '{OP_INSERT,     7'd1,   32'h1111_1111, 1'b1, '{ST_BADIDX, 32'h0,       7'd0}},
      '{OP_INSERT,     7'd0,   32'hFFFF_FFFF, 1'b1, '{ST_OK,     32'h0,       7'd1}},
      '{OP_PUSH_BACK,  7'd0,   32'h0,        1'b1, '{ST_OK,     32'h0,        7'd2}},
      '{OP_PUSH_FRONT, 7'd0,   32'hA5A5_A5A5, 1'b1, '{ST_OK,     32'h0,       7'd3}},
      '{OP_INSERT,     7'd3,   32'h5A5A_5A5A, 1'b1, '{ST_OK,     32'h0,       7'd4}},
      '{OP_INSERT,     7'd2,   32'h1234_5678, 1'b0, '{ST_OK,     32'h0,       7'd0}},
      '{OP_GET,        7'd0,   32'h0,        1'b1, '{ST_OK,     32'hA5A5_A5A5, 7'd5}},
      '{OP_GET,        7'd4,   32'h0,        1'b0, '{ST_OK,     32'h0,        7'd0}},
      '{OP_GET,        7'd5,   32'h0,        1'b1, '{ST_BADIDX, 32'h0,        7'd5}},
      '{OP_GET,        7'd127, 32'h0,        1'b1, '{ST_BADIDX, 32'h0,        7'd5}},
      '{OP_REMOVE,     7'd127, 32'h0,        1'b1, '{ST_BADIDX, 32'h0,        7'd5}},
      '{OP_INSERT,     7'd127, 32'hDEAD_BEEF, 1'b1, '{ST_BADIDX, 32'h0,       7'd5}},
      '{OP_REMOVE,     7'd1,   32'h0,        1'b0, '{ST_OK,     32'h0,        7'd0}},
      '{OP_POP_FRONT,  7'd0,   32'h0,        1'b0, '{ST_OK,     32'h0,        7'd0}},
      '{OP_POP_BACK,   7'd0,   32'h0,        1'b0, '{ST_OK,     32'h0,        7'd0}},
      '{OP_CLEAR,      7'd0,   32'h0,        1'b1, '{ST_OK,     32'h0,        7'd0}},
      '{OP_CLEAR,      7'd0,   32'h0,        1'b1, '{ST_OK,     32'h0,        7'd0}},
      '{OP_PUSH_BACK,  7'd0,   32'h0000_0001, 1'b1, '{ST_OK,     32'h0,       7'd1}},
      '{OP_GET,        7'd0,   32'h0,        1'b1, '{ST_OK,     32'h0000_0001, 7'd1}},
      '{OP_POP_BACK,   7'd0,   32'h0,        1'b1, '{ST_OK,     32'h0000_0001, 7'd0}}
   };

   // capacity settings walked by the random part; the second one drops below the count
   phase_row_type capacity_plan [10] = '{
      '{7'd64,  MIX_FILL,  110},
      '{7'd3,   MIX_EVEN,  40},
      '{7'd127, MIX_FILL,  60},
      '{7'd100, MIX_DRAIN, 60},
      '{7'd0,   MIX_EVEN,  40},
      '{7'd1,   MIX_EVEN,  50},
      '{7'd2,   MIX_EVEN,  40},
      '{7'd64,  MIX_EVEN,  100},
      '{7'd64,  MIX_DRAIN, 80},
      '{7'd33,  MIX_FILL,  50}
   };

   indexed_list_store_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // list behavior: applies one operation to the shadow list, returns its result
   function automatic list_result_type list_predict(op_type op, logic [IDX_W-1:0] idx,
                                                    logic [DATA_W-1:0] val);
      list_result_type r;
      int unsigned     room;
      int unsigned     pos;
      r    = '{ST_OK, '0, '0};
      room = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
      pos  = idx;
      case (op) inside
         OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: begin
            if (op == OP_PUSH_BACK) pos = shadow_count;
            else if (op == OP_PUSH_FRONT) pos = 0;
            // full wins over a bad index
            if (shadow_count >= room) r.st = ST_FULL;
            else if (pos > shadow_count) r.st = ST_BADIDX;
            else begin
               for (int k = shadow_count; k > pos; k--) shadow_words[k] = shadow_words[k-1];
               shadow_words[pos] = val;
               shadow_count++;
            end
         end
         OP_GET: begin
            if (shadow_count == 0) r.st = ST_EMPTY;
            else if (pos >= shadow_count) r.st = ST_BADIDX;
            else r.word = shadow_words[pos];
         end
         OP_CLEAR: begin
            shadow_count = 0;
         end
         default: begin
            // pop back, pop front and remove share the shift-down path
            if (op == OP_POP_BACK) pos = shadow_count - 1;
            else if (op == OP_POP_FRONT) pos = 0;
            if (shadow_count == 0) r.st = ST_EMPTY;
            else if (pos >= shadow_count) r.st = ST_BADIDX;
            else begin
               r.word = shadow_words[pos];
               for (int k = pos; k + 1 < shadow_count; k++) shadow_words[k] = shadow_words[k+1];
               shadow_count--;
            end
         end
      endcase
      r.cnt = COUNT_W'(shadow_count);
      return r;
   endfunction

   // offer one request and record its expected result once accepted
   task automatic send_op(op_type op, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val,
                          bit known, list_result_type known_res);
      list_result_type predicted;
      req_tvalid <= 1'b1;
      req_tdata  <= {{PAD_W{1'b0}}, val, idx, op};
      do @(posedge clock); while (!req_tready);
      predicted = list_predict(op, idx, val);
      pending_results.push_back(known ? known_res : predicted);
   endtask

   task automatic idle_gap(bit calm);
      int unsigned n;
      n = calm ? 0 : pick_gap();
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // hold off until every outstanding transaction has returned
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] cap);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      shadow_cap   = cap;
   endtask

   // stimulus
   initial begin
      op_type            op;
      logic [IDX_W-1:0]  idx;
      logic [DATA_W-1:0] val;
      int unsigned       grow_pct;
      int unsigned       hi;
      bit                calm;
      foreach (shadow_words[k]) shadow_words[k] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_ops[i]) begin
         send_op(directed_ops[i].op, directed_ops[i].idx, directed_ops[i].val,
                 directed_ops[i].known, directed_ops[i].res);
         idle_gap(1'b0);
      end

      foreach (capacity_plan[p]) begin
         wait_drained();
         write_capacity(capacity_plan[p].cap);
         calm     = (p % 3 == 2);
         grow_pct = (capacity_plan[p].mix == MIX_FILL)  ? 80 :
                    (capacity_plan[p].mix == MIX_DRAIN) ? 20 : 50;
         repeat (capacity_plan[p].items) begin
            // growing ops against shrinking ops, clear kept rare
            if ($urandom_range(0, 99) < grow_pct)
               op = op_type'($urandom_range(OP_PUSH_BACK, OP_INSERT));
            else if ($urandom_range(0, 19) == 0)
               op = OP_CLEAR;
            else
               op = op_type'($urandom_range(OP_POP_BACK, OP_GET));
            // index mostly in the legal window, sometimes anywhere
            if (op == OP_INSERT) hi = shadow_count;
            else hi = (shadow_count == 0) ? 0 : shadow_count - 1;
            if ($urandom_range(0, 4) == 0) idx = IDX_W'($urandom_range(0, 127));
            else idx = IDX_W'($urandom_range(0, hi));
            case ($urandom_range(0, 15))
               0:       val = '0;
               1:       val = '1;
               default: val = $urandom;
            endcase
            send_op(op, idx, val, 1'b0, '0);
            if ($urandom_range(0, 49) == 0) wait_drained();
            else idle_gap(calm);
         end
      end

      wait_drained();
      if (error_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   // result side back-pressure, with calm stretches
   always @(posedge clock) begin
      if (cycle_count % 256 == 0) ready_calm <= ($urandom_range(0, 2) == 0);
      if (ready_hold > 0) begin
         rsp_tready <= 1'b0;
         ready_hold <= ready_hold - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (!ready_calm && $urandom_range(0, 3) == 0) ready_hold <= pick_gap();
      end
   end

   // compare each returned transaction with the oldest expectation
   always @(posedge clock) begin
      list_result_type got;
      list_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.st   = status_type'(rsp_tdata[1:0]);
         got.word = rsp_tdata[33:2];
         got.cnt  = rsp_tdata[40:34];
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("%0t: unexpected result status=%0d value=%h count=%0d",
                        $realtime, got.st, got.word, got.cnt);
         end else begin
            want = pending_results.pop_front();
            if (got.st !== want.st || got.word !== want.word || got.cnt !== want.cnt) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("%0t: mismatch status %0d/%0d value %h/%h count %0d/%0d",
                           $realtime, want.st, got.st, want.word, got.word,
                           want.cnt, got.cnt);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= MAX_CYCLES) begin
         $display("Regression FAIL");
         $finish;
      end
   end

endmodule

[sim.f]
hw/rtl/ils_pkg.sv
hw/rtl/indexed_list_store_core.sv
verif/indexed_list_store_core_tb.sv
